/* hw/rtl/bpq_pkg.sv */
// Package for the bucket priority queue: sizes, opcodes, FSM states.
// No dependencies.
package bpq_pkg;
  localparam int NumElems = 1024;
  localparam int NumKeys  = 256;
  localparam int IdW      = $clog2(NumElems);
  localparam int KeyW     = $clog2(NumKeys);
  localparam int LinkW    = IdW + 1;   // msb set = null
  localparam int CurW     = KeyW + 1;  // cursor may reach max_key + 1

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_ELEM, ST_UNLINK, ST_UNLINK2, ST_PUSH_RD,
    ST_PUSH, ST_POP_RD, ST_POP_CHK, ST_POP_RD2, ST_POP_FIN, ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]      op;
    logic [IdW-1:0]  elem_id;
    logic [KeyW-1:0] key_value;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0] popped_id;
    logic           queue_empty;
  } rsp_t;
endpackage

/* hw/rtl/bpq_if.sv */
// Valid/ready channel carrying one word of type T.
// No dependencies; the payload type is the parameter T.
interface bpq_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/bucket_priority_queue.sv */
// Top level of the bucket priority queue: control sequencer plus RAMs.
// Depends on bpq_pkg, bpq_if, bpq_ram.
//
//  channel   dir  payload                      accepted when
//  in_if     in   op, elem_id, key_value       valid & ready
//  out_if    out  popped_id, queue_empty       valid & ready (pop only)
//  cfg       in   max_key (8b)                 cfg_we_i high
//
// Insert/update, from acceptance to the next ready: element read, unlink
// writes, head read, push, back link; an ignored update ends after the element
// read. Pop: after acceptance, a head read and a check per bucket visited from
// the cursor (the hit included), then removal of the head and a null back link
// for its successor, then the result holds in the output register; an empty pop
// goes to the output once the cursor passes max_key. The steps come from the
// single port on each RAM (head, next, prev, key). After reset a clearing pass
// nulls every RAM entry; no word is taken meanwhile. A stalled result holds in
// the output register and blocks the next word.
module bucket_priority_queue
  import bpq_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [KeyW-1:0] cfg_wdata_i,
  bpq_if.sink             in_if,
  bpq_if.source           out_if
);
  localparam logic [LinkW-1:0] Nil = {1'b1, {IdW{1'b0}}};
  localparam logic [CurW-1:0]  Absent = {1'b1, {KeyW{1'b0}}};

  state_e state_q, state_d;
  logic [KeyW-1:0] max_key_q;
  logic [CurW-1:0] cur_q, cur_d;
  logic [IdW:0]    clr_q, clr_d;
  req_t            req_q, req_d;
  logic [LinkW-1:0] p_q, p_d, n_q, n_d;
  logic [CurW-1:0]  k_q, k_d;
  rsp_t             rsp_q, rsp_d;

  // RAM ports
  logic            hd_we, nx_we, pv_we, ky_we;
  logic [KeyW-1:0] hd_a;
  logic [IdW-1:0]  nx_a, pv_a, ky_a;
  logic [LinkW-1:0] hd_w, nx_w, pv_w, hd_r, nx_r, pv_r;
  logic [CurW-1:0]  ky_w, ky_r;

  bpq_ram #(.Width(LinkW), .Depth(NumKeys)) u_head (
    .clk_i, .we_i(hd_we), .addr_i(hd_a), .wdata_i(hd_w), .rdata_o(hd_r));
  bpq_ram #(.Width(LinkW), .Depth(NumElems)) u_next (
    .clk_i, .we_i(nx_we), .addr_i(nx_a), .wdata_i(nx_w), .rdata_o(nx_r));
  bpq_ram #(.Width(LinkW), .Depth(NumElems)) u_prev (
    .clk_i, .we_i(pv_we), .addr_i(pv_a), .wdata_i(pv_w), .rdata_o(pv_r));
  bpq_ram #(.Width(CurW), .Depth(NumElems)) u_key (
    .clk_i, .we_i(ky_we), .addr_i(ky_a), .wdata_i(ky_w), .rdata_o(ky_r));

  logic [CurW-1:0] lim;
  assign lim = {1'b0, max_key_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      max_key_q <= '1;
      cur_q     <= {1'b1, {KeyW{1'b0}}};
      clr_q     <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        max_key_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    p_q   <= p_d;
    n_q   <= n_d;
    k_q   <= k_d;
    rsp_q <= rsp_d;
  end

  assign out_if.data  = rsp_q;
  assign out_if.valid = (state_q == ST_OUT);
  assign in_if.ready  = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cur_d = cur_q; clr_d = clr_q;
    req_d = req_q; p_d = p_q; n_d = n_q; k_d = k_q; rsp_d = rsp_q;
    hd_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; ky_we = 1'b0;
    hd_a = req_q.key_value; nx_a = req_q.elem_id;
    pv_a = req_q.elem_id;   ky_a = req_q.elem_id;
    hd_w = Nil; nx_w = Nil; pv_w = Nil; ky_w = Absent;
    unique case (state_q)
      ST_CLEAR: begin
        // sweep every entry to null / absent
        hd_we = 1'b1; nx_we = 1'b1; pv_we = 1'b1; ky_we = 1'b1;
        hd_a = clr_q[KeyW-1:0]; nx_a = clr_q[IdW-1:0];
        pv_a = clr_q[IdW-1:0];  ky_a = clr_q[IdW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q[IdW-1:0] == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_if.valid) begin
          req_d = in_if.data;
          nx_a = in_if.data.elem_id; pv_a = in_if.data.elem_id;
          ky_a = in_if.data.elem_id;
          case (in_if.data.op)
            OP_INSERT, OP_UPDATE: state_d = ST_RD_ELEM;
            OP_POP:               state_d = ST_POP_RD;
            default:              state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD_ELEM: begin
        p_d = pv_r; n_d = nx_r; k_d = ky_r;
        if (ky_r == Absent) begin
          state_d = (req_q.op == OP_UPDATE) ? ST_IDLE : ST_PUSH_RD;
        end else begin
          state_d = ST_UNLINK;
        end
      end
      ST_UNLINK: begin
        // fix predecessor link (or bucket head) and successor back link
        if (p_q[IdW]) begin
          hd_we = 1'b1; hd_a = k_q[KeyW-1:0]; hd_w = n_q;
        end else begin
          nx_we = 1'b1; nx_a = p_q[IdW-1:0]; nx_w = n_q;
        end
        if (!n_q[IdW]) begin
          pv_we = 1'b1; pv_a = n_q[IdW-1:0]; pv_w = p_q;
        end
        state_d = ST_UNLINK2;
      end
      ST_UNLINK2: begin
        state_d = ST_PUSH_RD;
      end
      ST_PUSH_RD: begin
        hd_a = req_q.key_value;
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        hd_we = 1'b1; hd_w = {1'b0, req_q.elem_id};
        nx_we = 1'b1; nx_w = hd_r;
        pv_we = 1'b1; pv_w = Nil;
        ky_we = 1'b1; ky_w = {1'b0, req_q.key_value};
        n_d = hd_r;
        if ({1'b0, req_q.key_value} < cur_q) cur_d = {1'b0, req_q.key_value};
        state_d = hd_r[IdW] ? ST_IDLE : ST_UNLINK2;
        if (!hd_r[IdW]) begin
          // old head needs a back link; reuse n/k to do it next cycle
          state_d = ST_POP_FIN;
          k_d = Absent;
        end
      end
      ST_POP_RD: begin
        hd_a = cur_q[KeyW-1:0];
        if (cur_q > lim) begin
          // hold the cursor where the scan stopped
          rsp_d = '{popped_id: '0, queue_empty: 1'b1};
          state_d = ST_OUT;
        end else begin
          state_d = ST_POP_CHK;
        end
      end
      ST_POP_CHK: begin
        if (hd_r[IdW]) begin
          cur_d = cur_q + 1'b1;
          state_d = ST_POP_RD;
        end else begin
          p_d = hd_r;
          nx_a = hd_r[IdW-1:0];
          state_d = ST_POP_RD2;
        end
      end
      ST_POP_RD2: begin
        // head's successor becomes new head; clear the popped entry
        hd_we = 1'b1; hd_a = cur_q[KeyW-1:0]; hd_w = nx_r;
        nx_we = 1'b1; nx_a = p_q[IdW-1:0]; nx_w = Nil;
        pv_we = 1'b1; pv_a = p_q[IdW-1:0]; pv_w = Nil;
        ky_we = 1'b1; ky_a = p_q[IdW-1:0]; ky_w = Absent;
        n_d = nx_r;
        k_d = {1'b1, {KeyW{1'b0}}} + 1'b1;
        rsp_d = '{popped_id: p_q[IdW-1:0], queue_empty: 1'b0};
        state_d = ST_POP_FIN;
      end
      ST_POP_FIN: begin
        // back link of new/old head
        if (!n_q[IdW]) begin
          pv_we = 1'b1; pv_a = n_q[IdW-1:0];
          pv_w = (k_q == Absent) ? {1'b0, req_q.elem_id} : Nil;
        end
        state_d = (k_q == Absent) ? ST_IDLE : ST_OUT;
      end
      ST_OUT: begin
        if (out_if.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // A result is shown only after a pop request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(state_q) == ST_POP_RD || $past(state_q) == ST_POP_FIN)
    else $error("result without pop");
  // No word is taken during the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_if.ready)
    else $error("ready during clear");
  // Empty pop leaves cursor above max_key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data.queue_empty) |-> cur_q > lim)
    else $error("cursor not past max_key on empty");
endmodule

/* hw/rtl/bpq_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module bpq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
